### rtl/lbl_pkg.sv
// Shared codes and controller/datapath interface types for the LCA query core.
// No dependencies; used by lbl_ctrl, lbl_datapath and the top level.
package lbl_pkg;

  // Input field widths fixed by the item format.
  localparam int CMD_W = 2;
  localparam int LVL_W = 4;

  // Item command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_DEPTH = 2'd0,
    CMD_ANC   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_code_e;

  // Level used to address the ancestor table.
  typedef enum logic [1:0] {
    LVL_STEP = 2'd0,
    LVL_MID  = 2'd1,
    LVL_HI   = 2'd2,
    LVL_ZERO = 2'd3
  } lvl_sel_e;

  // Source of the query answer.
  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_A    = 2'd1,
    RES_RDA  = 2'd2
  } res_src_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_query;
    logic     order;
    logic     rd_en;
    lvl_sel_e rd_lvl;
    logic     lift_apply;
    logic     step_i;
    logic     round_init;
    logic     srch_apply;
    logic     jump_apply;
    logic     round_inc;
    logic     res_load;
    res_src_e res_src;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad_nodes;
    logic dh_too_big;
    logic lift_bit;
    logic i_zero;
    logic rda_none;
    logic ab_equal;
    logic ab_none;
    logic search_open;
    logic hi_neg;
    logic round_last;
  } dp_stat_t;

endpackage

### rtl/lbl_datapath.sv
// Datapath of the LCA query core: depth and ancestor memories, working nodes,
// lift and search counters. Depends on lbl_pkg; driven by lbl_ctrl.
module lbl_datapath #(
  parameter int NODES = 1024,
  parameter int LEVELS = 10,
  localparam int NW = $clog2(NODES),
  localparam int AW = $clog2(NODES + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [lbl_pkg::CMD_W-1:0] command_i,
  input  logic [NW-1:0]            node_a_i,
  input  logic [NW-1:0]            node_b_i,
  input  logic [lbl_pkg::LVL_W-1:0] level_i,
  input  logic [AW-1:0]            ancestor_i,
  input  logic [NW-1:0]            depth_i,
  input  lbl_pkg::ctrl_cmd_t       cmd_i,
  output lbl_pkg::dp_stat_t        stat_o,
  output logic [AW-1:0]            result_o
);

  localparam int DW = (NW > LEVELS) ? NW : LEVELS;
  localparam int LIW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int RW = $clog2(LEVELS + 1);
  localparam int ENTRIES = NODES * LEVELS;
  localparam int AAW = $clog2(ENTRIES);
  localparam logic [AW-1:0] NONE_C = AW'(NODES);

  logic [NW-1:0]  dep_mem [NODES];
  logic [AW-1:0]  anc_mem [ENTRIES];

  logic [NW-1:0]  dep_rd_a_q, dep_rd_b_q;
  logic [AW-1:0]  anc_rd_a_q, anc_rd_b_q;
  logic [AW-1:0]  a_q, b_q, res_q;
  logic [DW-1:0]  dh_q;
  logic [LIW-1:0] i_q;
  logic [RW-1:0]  round_q;
  logic [LIW:0]   lo_q, hi_q;

  logic           node_a_ok, node_b_ok;
  logic           wr_dep, wr_anc, is_query;
  logic [AW-1:0]  anc_norm;
  logic [AAW-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic [LIW-1:0] rd_lvl, mid;
  logic [LIW+1:0] mid_sum;
  logic           da_lt_db, anc_eq, search_open;
  logic [NW-1:0]  diff;
  logic [DW-1:0]  diff_ext;

  // Decode writes and range checks
  assign node_a_ok = AW'(node_a_i) < NONE_C;
  assign node_b_ok = AW'(node_b_i) < NONE_C;
  assign is_query  = command_i == lbl_pkg::CMD_QUERY;
  assign wr_dep    = accept_i && command_i == lbl_pkg::CMD_DEPTH && node_a_ok;
  assign wr_anc    = accept_i && command_i == lbl_pkg::CMD_ANC && node_a_ok &&
                     (int'(level_i) < LEVELS);
  assign anc_norm  = (ancestor_i >= NONE_C) ? NONE_C : ancestor_i;
  assign wr_addr   = AAW'(node_a_i) * AAW'(LEVELS) + AAW'(level_i);

  // Search midpoint, valid while lo <= hi
  assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid         = mid_sum[LIW:1];
  assign search_open = !hi_q[LIW] && (lo_q <= hi_q);

  // Select the level for the ancestor lookup
  always_comb begin
    unique case (cmd_i.rd_lvl)
      lbl_pkg::LVL_STEP: rd_lvl = i_q;
      lbl_pkg::LVL_MID:  rd_lvl = mid;
      lbl_pkg::LVL_HI:   rd_lvl = hi_q[LIW-1:0];
      lbl_pkg::LVL_ZERO: rd_lvl = '0;
      default:           rd_lvl = '0;
    endcase
  end

  assign rd_addr_a = AAW'(a_q[NW-1:0]) * AAW'(LEVELS) + AAW'(rd_lvl);
  assign rd_addr_b = AAW'(b_q[NW-1:0]) * AAW'(LEVELS) + AAW'(rd_lvl);

  // Depth memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_dep) begin
      dep_mem[node_a_i] <= depth_i;
    end
    if (accept_i && is_query) begin
      dep_rd_a_q <= dep_mem[node_a_i];
      dep_rd_b_q <= dep_mem[node_b_i];
    end
  end

  // Ancestor memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_anc) begin
      anc_mem[wr_addr] <= anc_norm;
    end
    if (cmd_i.rd_en) begin
      anc_rd_a_q <= anc_mem[rd_addr_a];
      anc_rd_b_q <= anc_mem[rd_addr_b];
    end
  end

  // Order the nodes by depth
  assign da_lt_db = dep_rd_a_q < dep_rd_b_q;
  assign diff     = da_lt_db ? (dep_rd_b_q - dep_rd_a_q) : (dep_rd_a_q - dep_rd_b_q);
  assign diff_ext = DW'(diff);
  assign anc_eq   = anc_rd_a_q == anc_rd_b_q;

  // Working nodes, depth difference and answer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) begin
      a_q <= AW'(node_a_i);
      b_q <= AW'(node_b_i);
    end else if (cmd_i.order) begin
      if (da_lt_db) begin
        a_q <= b_q;
        b_q <= a_q;
      end
      dh_q <= diff_ext;
    end else if (cmd_i.lift_apply) begin
      a_q <= anc_rd_a_q;
    end else if (cmd_i.jump_apply) begin
      a_q <= anc_rd_a_q;
      b_q <= anc_rd_b_q;
    end
    if (cmd_i.res_load) begin
      case (cmd_i.res_src)
        lbl_pkg::RES_NONE: res_q <= NONE_C;
        lbl_pkg::RES_A:    res_q <= a_q;
        lbl_pkg::RES_RDA:  res_q <= anc_rd_a_q;
        default:           res_q <= NONE_C;
      endcase
    end
  end

  // Lift index, round count and search bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q     <= '0;
      round_q <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
    end else begin
      if (cmd_i.order) begin
        i_q     <= LIW'(LEVELS - 1);
        round_q <= '0;
      end else begin
        if (cmd_i.step_i) begin
          i_q <= i_q - LIW'(1);
        end
        if (cmd_i.round_inc) begin
          round_q <= round_q + RW'(1);
        end
      end
      if (cmd_i.round_init) begin
        lo_q <= '0;
        hi_q <= (LIW + 1)'(LEVELS - 1);
      end else if (cmd_i.srch_apply) begin
        if (anc_eq) begin
          hi_q <= {1'b0, mid} - (LIW + 1)'(1);
        end else begin
          lo_q <= {1'b0, mid} + (LIW + 1)'(1);
        end
      end
    end
  end

  // Report status
  assign stat_o.bad_nodes   = !node_a_ok || !node_b_ok;
  assign stat_o.dh_too_big  = (diff_ext >> LEVELS) != '0;
  assign stat_o.lift_bit    = dh_q[i_q];
  assign stat_o.i_zero      = i_q == '0;
  assign stat_o.rda_none    = anc_rd_a_q >= NONE_C;
  assign stat_o.ab_equal    = a_q == b_q;
  assign stat_o.ab_none     = (a_q >= NONE_C) || (b_q >= NONE_C);
  assign stat_o.search_open = search_open;
  assign stat_o.hi_neg      = hi_q[LIW];
  assign stat_o.round_last  = round_q == RW'(LEVELS);

  assign result_o = res_q;

`ifndef NO_ASSERTIONS
  a_srch_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.srch_apply |-> search_open)
    else $error("search step applied with an empty interval");
  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.round_inc |-> round_q < RW'(LEVELS))
    else $error("round count advanced past the last round");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_i |-> i_q != '0)
    else $error("lift index stepped below level zero");
`endif

endmodule

### rtl/lbl_ctrl.sv
// Controller of the LCA query core: sequences the depth compare, lift steps,
// search rounds and answer delivery. Depends on lbl_pkg; drives lbl_datapath.
module lbl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               query_i,
  input  logic               out_free_i,
  input  lbl_pkg::dp_stat_t  stat_i,
  output lbl_pkg::ctrl_cmd_t cmd_o,
  output logic               idle_o,
  output logic               out_load_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEPTH,
    S_LIFT,
    S_LIFT_WAIT,
    S_ROUND,
    S_SRCH,
    S_SRCH_WAIT,
    S_PAR_WAIT,
    S_JUMP_WAIT,
    S_FINAL,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.rd_lvl   = lbl_pkg::LVL_STEP;
    cmd_o.res_src  = lbl_pkg::RES_NONE;
    out_load_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept_i && query_i) begin
          if (stat_i.bad_nodes) begin
            cmd_o.res_load = 1'b1;
            state_d        = S_DONE;
          end else begin
            cmd_o.load_query = 1'b1;
            state_d          = S_DEPTH;
          end
        end
      end
      S_DEPTH: begin
        cmd_o.order = 1'b1;
        if (stat_i.dh_too_big) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
        end else begin
          state_d = S_LIFT;
        end
      end
      S_LIFT: begin
        if (stat_i.lift_bit) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_LIFT_WAIT;
        end else if (stat_i.i_zero) begin
          state_d = S_ROUND;
        end else begin
          cmd_o.step_i = 1'b1;
        end
      end
      S_LIFT_WAIT: begin
        cmd_o.lift_apply = 1'b1;
        if (stat_i.rda_none) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
        end else if (stat_i.i_zero) begin
          state_d = S_ROUND;
        end else begin
          cmd_o.step_i = 1'b1;
          state_d      = S_LIFT;
        end
      end
      S_ROUND: begin
        if (stat_i.ab_equal) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_src  = lbl_pkg::RES_A;
          state_d        = S_DONE;
        end else if (stat_i.ab_none) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.round_init = 1'b1;
          state_d          = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd_o.rd_en = 1'b1;
        if (stat_i.search_open) begin
          cmd_o.rd_lvl = lbl_pkg::LVL_MID;
          state_d      = S_SRCH_WAIT;
        end else if (stat_i.hi_neg) begin
          cmd_o.rd_lvl = lbl_pkg::LVL_ZERO;
          state_d      = S_PAR_WAIT;
        end else begin
          cmd_o.rd_lvl = lbl_pkg::LVL_HI;
          state_d      = S_JUMP_WAIT;
        end
      end
      S_SRCH_WAIT: begin
        cmd_o.srch_apply = 1'b1;
        state_d          = S_SRCH;
      end
      S_PAR_WAIT: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_src  = lbl_pkg::RES_RDA;
        state_d        = S_DONE;
      end
      S_JUMP_WAIT: begin
        cmd_o.jump_apply = 1'b1;
        if (stat_i.round_last) begin
          state_d = S_FINAL;
        end else begin
          cmd_o.round_inc = 1'b1;
          state_d         = S_ROUND;
        end
      end
      S_FINAL: begin
        cmd_o.res_load = 1'b1;
        if (stat_i.ab_equal && !stat_i.ab_none) begin
          cmd_o.res_src = lbl_pkg::RES_A;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign idle_o = state_q == S_IDLE;

`ifndef NO_ASSERTIONS
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> state_q == S_IDLE)
    else $error("item accepted while a query is in progress");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |-> out_free_i)
    else $error("answer loaded over an untaken item");
  a_res_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |=> state_q == S_DONE)
    else $error("answer latched without moving to delivery");
`endif

endmodule

### rtl/lca_binary_lifting_query_core.sv
// Top level of the LCA query core over a host-loaded binary-lifting table.
// Depends on lbl_pkg, lbl_ctrl and lbl_datapath; holds the handshakes.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o | command, node_a, node_b, level,
//           |           |                         | ancestor, depth
//   out     | output    | out_valid_o / out_stall_i | common_ancestor
//
// Every ancestor lookup makes a registered read of the ancestor memory, which has one
// write port and two read ports, and uses the read data in its wait state.
// Reset clears control state only; both tables are undefined until written.
// in_stall_o is high while a query runs; an answer waits in the output
// register under out_stall_i while the next item is accepted.
module lca_binary_lifting_query_core #(
  parameter int NODES = 1024,
  parameter int LEVELS = 10,
  localparam int NW = $clog2(NODES),
  localparam int AW = $clog2(NODES + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [lbl_pkg::CMD_W-1:0] command_i,
  input  logic [NW-1:0]             node_a_i,
  input  logic [NW-1:0]             node_b_i,
  input  logic [lbl_pkg::LVL_W-1:0] level_i,
  input  logic [AW-1:0]             ancestor_i,
  input  logic [NW-1:0]             depth_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [AW-1:0]             common_ancestor_o
);

  lbl_pkg::ctrl_cmd_t cmd;
  lbl_pkg::dp_stat_t  stat;
  logic               idle, accept, query, out_free, out_load;
  logic [AW-1:0]      result;
  logic               out_valid_q;
  logic [AW-1:0]      common_ancestor_q;

  // Accept items only between queries
  assign in_stall_o = !idle;
  assign accept     = in_valid_i && !in_stall_o;
  assign query      = command_i == lbl_pkg::CMD_QUERY;
  assign out_free   = !out_valid_q || !out_stall_i;

  lbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .query_i    (query),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idle_o     (idle),
    .out_load_o (out_load)
  );

  lbl_datapath #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .command_i  (command_i),
    .node_a_i   (node_a_i),
    .node_b_i   (node_b_i),
    .level_i    (level_i),
    .ancestor_i (ancestor_i),
    .depth_i    (depth_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .result_o   (result)
  );

  // Output register: load a finished answer, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      common_ancestor_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign common_ancestor_o = common_ancestor_q;

endmodule

### tb/sv/tb_lca_binary_lifting_query_core.sv
// Testbench for lca_binary_lifting_query_core: loads lifting tables, queries LCAs, checks answers.
// Depends on lbl_pkg and the core; keeps its own copies of both tables to predict each answer.
module tb_lca_binary_lifting_query_core;

  localparam int NODES = 1024;
  localparam int LEVELS = 10;
  localparam int NW = 10;
  localparam int AW = 11;
  localparam logic [AW-1:0] NONE = AW'(NODES);
  localparam logic [lbl_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int TBL_PLAN = 0;
  localparam int TBL_LIVE = 1;
  localparam int ITEMS = 500;
  localparam int MIN_ANSWERS = 60;
  localparam int MAX_GROW = 16;
  localparam int HOLD_AFTER = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE = 200;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [lbl_pkg::CMD_W-1:0] cmd;
    logic [NW-1:0]             node_a;
    logic [NW-1:0]             node_b;
    logic [lbl_pkg::LVL_W-1:0] lvl;
    logic [AW-1:0]             anc;
    logic [NW-1:0]             dep;
  } lca_item_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [lbl_pkg::CMD_W-1:0] cmd = '0;
  logic [NW-1:0]             node_a = '0;
  logic [NW-1:0]             node_b = '0;
  logic [lbl_pkg::LVL_W-1:0] lvl = '0;
  logic [AW-1:0]             anc = '0;
  logic [NW-1:0]             dep = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [AW-1:0]             common_anc;

  // Two copies of the tables: one tracks what the stimulus has written, one what was accepted
  bit [NW-1:0]     tbl_depth [2][NODES];
  bit [AW-1:0]     tbl_anc   [2][NODES][LEVELS];
  bit              depth_set [2][NODES];
  bit [LEVELS-1:0] anc_set   [2][NODES];
  bit              walk_safe;

  lca_item_t     pending[$];
  logic [AW-1:0] answers_due[$];
  logic [NW-1:0] grove[$];
  logic [NW-1:0] settled[$];
  bit            in_settled [NODES];
  int            planned_items = 0;
  int            planned_queries = 0;
  int            answers_seen = 0;
  int            errors = 0;
  int            quiet_cycles = 0;
  logic          in_fire = 1'b0;
  logic          out_fire = 1'b0;
  int            gap_left = 0;
  bit            drv_burst = 1'b0;
  int            wait_left = 0;
  int            hold_left = 0;
  bit            hold_used = 1'b0;
  bit            rx_burst = 1'b0;

  lca_binary_lifting_query_core #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .command_i         (cmd),
    .node_a_i          (node_a),
    .node_b_i          (node_b),
    .level_i           (lvl),
    .ancestor_i        (anc),
    .depth_i           (dep),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .common_ancestor_o (common_anc)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // A node is fully loaded once its depth and every lifting level are written
  function automatic bit node_ok(int t, logic [AW-1:0] n);
    return n < NODES && depth_set[t][n[NW-1:0]] && (&anc_set[t][n[NW-1:0]]);
  endfunction

  function automatic logic [AW-1:0] hop(int t, logic [AW-1:0] n, int k);
    if (n >= NONE || k < 0 || k >= LEVELS) return NONE;
    if (!node_ok(t, n)) walk_safe = 1'b0;
    return tbl_anc[t][n[NW-1:0]][k];
  endfunction

  // Predict the answer of one query; clear walk_safe if it touches a partly loaded node
  function automatic logic [AW-1:0] lca_of(int t, logic [NW-1:0] qa, logic [NW-1:0] qb);
    logic [AW-1:0] a, b;
    logic [NW-1:0] dh;
    int i, r, lo, hi, mid;
    walk_safe = node_ok(t, {1'b0, qa}) && node_ok(t, {1'b0, qb});
    a = {1'b0, qa};
    b = {1'b0, qb};
    if (tbl_depth[t][qa] < tbl_depth[t][qb]) begin
      a = {1'b0, qb};
      b = {1'b0, qa};
    end
    dh = tbl_depth[t][a[NW-1:0]] - tbl_depth[t][b[NW-1:0]];
    if ((dh >> LEVELS) != 0) return NONE;
    // lift the deeper node by the depth difference
    for (i = LEVELS - 1; i >= 0; i--) begin
      if (dh[i]) begin
        a = hop(t, a, i);
        if (a >= NONE) return NONE;
      end
    end
    // search the highest level whose ancestors still differ, then jump both
    for (r = 0; r <= LEVELS; r++) begin
      if (a == b) return a;
      if (a >= NONE || b >= NONE) return NONE;
      lo = 0;
      hi = LEVELS - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (hop(t, a, mid) == hop(t, b, mid)) hi = mid - 1;
        else lo = mid + 1;
      end
      if (hi < 0) return hop(t, a, 0);
      a = hop(t, a, hi);
      b = hop(t, b, hi);
    end
    if (a == b && a < NONE) return a;
    return NONE;
  endfunction

  // Apply a write item to one table copy
  function automatic void absorb(int t, lca_item_t it);
    case (it.cmd)
      lbl_pkg::CMD_DEPTH: begin
        tbl_depth[t][it.node_a] = it.dep;
        depth_set[t][it.node_a] = 1'b1;
      end
      lbl_pkg::CMD_ANC: begin
        if (it.lvl < LEVELS) begin
          tbl_anc[t][it.node_a][it.lvl] = (it.anc >= NONE) ? NONE : it.anc;
          anc_set[t][it.node_a][it.lvl] = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic lca_item_t scramble();
    lca_item_t it;
    it.cmd = lbl_pkg::CMD_W'($urandom_range(0, 3));
    it.node_a = NW'($urandom_range(0, NODES - 1));
    it.node_b = NW'($urandom_range(0, NODES - 1));
    it.lvl = lbl_pkg::LVL_W'($urandom_range(0, 15));
    it.anc = AW'($urandom_range(0, (1 << AW) - 1));
    it.dep = NW'($urandom_range(0, NODES - 1));
    return it;
  endfunction

  function automatic logic [AW-1:0] none_code();
    if ($urandom_range(0, 1) != 0) return NONE;
    return AW'($urandom_range(NODES + 1, (1 << AW) - 1));
  endfunction

  function automatic logic [NW-1:0] pick_settled();
    return settled[$urandom_range(0, settled.size() - 1)];
  endfunction

  task automatic enqueue(lca_item_t it);
    pending.push_back(it);
    absorb(TBL_PLAN, it);
    planned_items++;
    if (it.cmd == lbl_pkg::CMD_QUERY) planned_queries++;
  endtask

  task automatic plan_depth(logic [NW-1:0] n, logic [NW-1:0] d);
    lca_item_t it;
    it = scramble();
    it.cmd = lbl_pkg::CMD_DEPTH;
    it.node_a = n;
    it.dep = d;
    enqueue(it);
  endtask

  task automatic plan_link(logic [NW-1:0] n, int k, logic [AW-1:0] v);
    lca_item_t it;
    it = scramble();
    it.cmd = lbl_pkg::CMD_ANC;
    it.node_a = n;
    it.lvl = lbl_pkg::LVL_W'(k);
    it.anc = v;
    enqueue(it);
  endtask

  // Issue a query only if every node it walks through is fully loaded
  task automatic plan_query(logic [NW-1:0] a, logic [NW-1:0] b);
    lca_item_t it;
    void'(lca_of(TBL_PLAN, a, b));
    if (walk_safe) begin
      it = scramble();
      it.cmd = lbl_pkg::CMD_QUERY;
      it.node_a = a;
      it.node_b = b;
      enqueue(it);
    end
  endtask

  task automatic settle_node(logic [NW-1:0] n);
    if (!in_settled[n]) begin
      in_settled[n] = 1'b1;
      settled.push_back(n);
    end
  endtask

  // Build a random forest and load it; depth gaps above one give a sparse, skewed table
  task automatic grow_forest(int count, int gap_max, int chain_pct);
    logic [NW-1:0] ids [MAX_GROW];
    int up [MAX_GROW];
    int dpt [MAX_GROW];
    int j, k, p, target;
    bit dup;
    grove.delete();
    for (j = 0; j < count; j++) begin
      do begin
        ids[j] = NW'($urandom_range(0, NODES - 1));
        dup = 1'b0;
        for (p = 0; p < j; p++) if (ids[p] == ids[j]) dup = 1'b1;
      end while (dup);
      if (j == 0 || $urandom_range(0, 9) == 0) p = -1;
      else if ($urandom_range(0, 99) < chain_pct) p = j - 1;
      else p = $urandom_range(0, j - 1);
      up[j] = p;
      if (p < 0) dpt[j] = $urandom_range(0, (gap_max > 1) ? 300 : NODES - 1 - count);
      else dpt[j] = dpt[p] + $urandom_range(1, gap_max);
      if (dpt[j] > NODES - 1) dpt[j] = NODES - 1;
      grove.push_back(ids[j]);
      settle_node(ids[j]);
    end
    for (j = 0; j < count; j++) begin
      plan_depth(ids[j], NW'(dpt[j]));
      for (k = 0; k < LEVELS; k++) begin
        target = dpt[j] - (1 << k);
        p = up[j];
        while (p >= 0 && dpt[p] > target) p = up[p];
        plan_link(ids[j], k, (p < 0) ? none_code() : {1'b0, ids[p]});
      end
    end
  endtask

  task automatic plan_pick_query();
    logic [NW-1:0] a, b;
    if ($urandom_range(0, 3) != 0) begin
      a = grove[$urandom_range(0, grove.size() - 1)];
      b = grove[$urandom_range(0, grove.size() - 1)];
    end else begin
      a = pick_settled();
      b = pick_settled();
    end
    plan_query(a, b);
  endtask

  // Noise: spare commands, ignored levels, corrupted entries and stray writes
  task automatic plan_noise();
    lca_item_t it;
    it = scramble();
    case ($urandom_range(0, 4))
      0: begin
        it.cmd = CMD_SPARE;
        enqueue(it);
      end
      1: begin
        it.cmd = lbl_pkg::CMD_ANC;
        it.lvl = lbl_pkg::LVL_W'($urandom_range(LEVELS, 15));
        enqueue(it);
      end
      2: plan_link(pick_settled(), $urandom_range(0, LEVELS - 1),
                   ($urandom_range(0, 1) != 0) ? {1'b0, pick_settled()} : none_code());
      3: plan_depth(pick_settled(), NW'($urandom_range(0, NODES - 1)));
      default: begin
        it.cmd = ($urandom_range(0, 1) != 0) ? lbl_pkg::CMD_DEPTH : lbl_pkg::CMD_ANC;
        enqueue(it);
      end
    endcase
  endtask

  // Stimulus, end of run and verdict
  initial begin
    int k;
    int room;
    lca_item_t it;
    // directed: root 0, node 1023 whose second hop is missing, two self-looping deep nodes
    plan_depth(10'd0, 10'd0);
    for (k = 0; k < LEVELS; k++) plan_link(10'd0, k, (k == LEVELS - 1) ? 11'h7FF : NONE);
    plan_depth(10'd1023, 10'd3);
    for (k = 0; k < LEVELS; k++) plan_link(10'd1023, k, (k == 0) ? 11'd0 : NONE);
    plan_depth(10'd682, 10'd1023);
    for (k = 0; k < LEVELS; k++) plan_link(10'd682, k, 11'd682);
    plan_depth(10'd341, 10'd1023);
    for (k = 0; k < LEVELS; k++) plan_link(10'd341, k, 11'd341);
    settle_node(10'd0);
    settle_node(10'd1023);
    settle_node(10'd682);
    settle_node(10'd341);
    plan_link(10'd1023, 15, 11'd682);
    it = scramble();
    it.cmd = CMD_SPARE;
    enqueue(it);
    plan_query(10'd0, 10'd0);
    plan_query(10'd1023, 10'd1023);
    plan_query(10'd1023, 10'd0);
    plan_query(10'd0, 10'd1023);
    plan_query(10'd682, 10'd341);
    plan_query(10'd341, 10'd682);
    plan_query(10'd682, 10'd0);
    plan_query(10'd1023, 10'd341);

    // random: mostly freshly loaded forests with queries, some noise
    while (planned_items < ITEMS || planned_queries < MIN_ANSWERS) begin
      // size each forest to what is left of the item budget
      room = (ITEMS - planned_items) / (LEVELS + 1);
      if (room >= 3) begin
        grow_forest($urandom_range(3, (room < MAX_GROW) ? room : MAX_GROW),
                    ($urandom_range(0, 2) == 0) ? 200 : 1, $urandom_range(0, 100));
      end
      repeat ($urandom_range(6, 14)) begin
        if ($urandom_range(0, 4) == 0) plan_noise();
        else plan_pick_query();
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    do @(negedge clk); while (pending.size() != 0 || in_valid || answers_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Driver: offer the next item after a random gap, hold it while stalled
  always @(negedge clk) begin
    lca_item_t nxt;
    if (rst_n && (!in_valid || in_fire)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending.size() != 0) begin
        nxt = pending.pop_front();
        cmd <= nxt.cmd;
        node_a <= nxt.node_a;
        node_b <= nxt.node_b;
        lvl <= nxt.lvl;
        anc <= nxt.anc;
        dep <= nxt.dep;
        in_valid <= 1'b1;
        gap_left <= drv_burst ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 39) == 0) drv_burst <= !drv_burst;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall a random count after each answer, plus one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) begin
        wait_left = rx_burst ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      end
      if (!hold_used && answers_seen == HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_used = 1'b1;
      end
      out_stall <= (hold_left != 0) || (wait_left != 0);
      if (hold_left != 0) hold_left--;
      else if (wait_left != 0) wait_left--;
    end
  end

  // Monitor: update the table copy on accepted items, check accepted answers
  always @(posedge clk) begin
    lca_item_t got;
    logic [AW-1:0] want;
    in_fire <= rst_n && in_valid && !in_stall;
    out_fire <= rst_n && out_valid && !out_stall;
    if (rst_n && in_valid && !in_stall) begin
      got.cmd = cmd;
      got.node_a = node_a;
      got.node_b = node_b;
      got.lvl = lvl;
      got.anc = anc;
      got.dep = dep;
      absorb(TBL_LIVE, got);
      if (got.cmd == lbl_pkg::CMD_QUERY) begin
        answers_due.push_back(lca_of(TBL_LIVE, got.node_a, got.node_b));
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      answers_seen++;
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected answer, expected none, got %0d", $time, common_anc);
      end else begin
        want = answers_due.pop_front();
        if (common_anc !== want) begin
          errors++;
          $display("%0t: common_ancestor mismatch, expected %0d, got %0d",
                   $time, want, common_anc);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule

### files.f
rtl/lbl_pkg.sv
rtl/lbl_datapath.sv
rtl/lbl_ctrl.sv
rtl/lca_binary_lifting_query_core.sv
tb/sv/tb_lca_binary_lifting_query_core.sv
